### design/lca_pkg.sv
// shared types, command codes and the age color table for the life grid
`timescale 1ns / 1ps
package lca_pkg;

    localparam int GRID_COLS_DEF = 80;
    localparam int GRID_ROWS_DEF = 60;
    localparam int LIVE_MAX      = 8191;

    typedef enum logic [2:0] {
        CMD_TOGGLE = 3'd0,
        CMD_WRITE  = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_STEP   = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] col;
        logic [5:0] row;
        logic       value;
    } t_item;

    typedef struct packed {
        logic        alive;
        logic [7:0]  cell_years;
        logic [23:0] color;
        logic [12:0] live_count;
        logic [31:0] generation;
    } t_result;

    typedef struct packed {
        logic       alive;
        logic [7:0] age;
    } t_cell;

    // blue, green, red by age band
    function automatic logic [23:0] band_color(input logic [7:0] age);
        logic [23:0] c;
        if (age < 8'd3) begin
            c = {8'd80, 8'd255, 8'd160};
        end else if (age < 8'd6) begin
            c = {8'd130, 8'd220, 8'd60};
        end else if (age < 8'd10) begin
            c = {8'd210, 8'd160, 8'd50};
        end else begin
            c = {8'd255, 8'd110, 8'd130};
        end
        return c;
    endfunction

endpackage

### design/lca_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module lca_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4800
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/life_automaton_with_age.sv
// life grid with cell ages: command sequencer, neighbor counter and two grid banks
//
// input channel: i_valid / o_stall carry one command (t_item) per transfer.
// output channel: o_valid / i_stall carry one result (t_result) per command.
// commands are taken one at a time; o_stall is high while a command is in work.
// states per command, from transfer to result valid:
//   read, off-grid: S_FRD, S_FWAIT; toggle, write: S_RD, S_MOD, S_FRD, S_FWAIT
//   clear: S_CLR over every ram entry (one ram entry a cycle), S_FRD, S_FWAIT
//   step:  S_NB over every cell, then S_FRD, S_FWAIT; each cell reads its nine
//          neighborhood entries through the single grid read port, one a
//          cycle, and writes its next state into the other bank
// the banks swap at the end of a step, so no copy-back is needed.
// after reset every entry of the active bank is swept to zero, with o_stall
// high. a finished result waits in the output register while
// i_stall is high; the next command can be taken meanwhile, and its result
// waits inside until the output register is free.
`timescale 1ns / 1ps
module life_automaton_with_age
    import lca_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_stall,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_stall
);

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int CELLW = $bits(t_cell);
    localparam logic [AW-1:0] LAST_BASE = AW'((GRID_ROWS - 1) * GRID_COLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A    = AW'(GRID_COLS);
    localparam logic [CW-1:0] LAST_COL  = CW'(GRID_COLS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(GRID_ROWS - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_RD, S_MOD, S_NB, S_FRD, S_FWAIT
    } t_state;

    t_state        r_state;
    t_item         r_in;
    logic          r_inside;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_ci;
    logic          r_clr_cmd;
    logic          r_bank;
    logic [LW-1:0] r_live;
    logic [LW-1:0] r_acc;
    logic [31:0]   r_gen;
    logic [CW-1:0] r_x;
    logic [RW-1:0] r_y;
    logic [AW-1:0] r_bu, r_bm, r_bd;
    logic [3:0]    r_k;
    logic [3:0]    r_cnt;
    t_cell         r_here;
    logic          r_out_valid;
    t_result       r_res;

    logic          inside_c;
    logic [AW-1:0] idx_c;
    logic [AW-1:0] rb, nb_addr, here_addr, raddr, waddr;
    logic [CW-1:0] xm, xp, xsel;
    logic          we_cur, we_nxt;
    t_cell         wdata, rd0, rd1, rdata, mod_cell, nxt_cell;
    logic [3:0]    n_cnt;
    logic          slot_free;

    assign inside_c = (32'(i_item.col) < 32'(GRID_COLS)) && (32'(i_item.row) < 32'(GRID_ROWS));
    assign idx_c    = AW'(32'(i_item.row) * 32'(GRID_COLS) + 32'(i_item.col));

    // neighborhood address, row base plus wrapped column
    assign xm = (r_x == '0) ? LAST_COL : r_x - CW'(1);
    assign xp = (r_x == LAST_COL) ? '0 : r_x + CW'(1);

    always_comb begin
        case (r_k)
            4'd0, 4'd1, 4'd2: rb = r_bu;
            4'd3, 4'd4, 4'd5: rb = r_bm;
            default:          rb = r_bd;
        endcase
        case (r_k)
            4'd0, 4'd3, 4'd6: xsel = xm;
            4'd1, 4'd4, 4'd7: xsel = r_x;
            default:          xsel = xp;
        endcase
    end

    assign nb_addr   = rb + AW'(xsel);
    assign here_addr = r_bm + AW'(r_x);

    assign rdata = r_bank ? rd1 : rd0;

    // B3/S23 with age
    assign n_cnt          = r_cnt + 4'(rdata.alive);
    assign nxt_cell.alive = r_here.alive ? (n_cnt == 4'd2 || n_cnt == 4'd3) : (n_cnt == 4'd3);
    assign nxt_cell.age   = (r_here.alive && nxt_cell.alive) ? r_here.age + 8'd1 : 8'd0;

    assign mod_cell.alive = (r_in.command == CMD_TOGGLE) ? ~rdata.alive : r_in.value;
    assign mod_cell.age   = 8'd0;

    always_comb begin
        we_cur = 1'b0;
        we_nxt = 1'b0;
        waddr  = r_ci;
        wdata  = '0;
        raddr  = r_idx;
        case (r_state)
            S_CLR: begin
                we_cur = 1'b1;
            end
            S_MOD: begin
                we_cur = 1'b1;
                waddr  = r_idx;
                wdata  = mod_cell;
            end
            S_NB: begin
                raddr  = nb_addr;
                we_nxt = (r_k == 4'd9);
                waddr  = here_addr;
                wdata  = nxt_cell;
            end
            default: begin
            end
        endcase
    end

    lca_ram #(.WIDTH(CELLW), .DEPTH(CELLS)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    ((we_cur && !r_bank) || (we_nxt && r_bank)),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd0)
    );

    lca_ram #(.WIDTH(CELLW), .DEPTH(CELLS)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    ((we_cur && r_bank) || (we_nxt && !r_bank)),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd1)
    );

    assign slot_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ci        <= '0;
            r_clr_cmd   <= 1'b0;
            r_bank      <= 1'b0;
            r_live      <= '0;
            r_gen       <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_ci <= r_ci + AW'(1);
                    if (r_ci == LAST_CELL) begin
                        r_live <= '0;
                        if (r_clr_cmd) begin
                            r_gen   <= '0;
                            r_state <= S_FRD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_in     <= i_item;
                        r_inside <= inside_c;
                        r_idx    <= inside_c ? idx_c : '0;
                        case (i_item.command)
                            CMD_TOGGLE, CMD_WRITE: begin
                                r_state <= inside_c ? S_RD : S_FRD;
                            end
                            CMD_CLEAR: begin
                                r_ci      <= '0;
                                r_clr_cmd <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            CMD_STEP: begin
                                r_x     <= '0;
                                r_y     <= '0;
                                r_bu    <= LAST_BASE;
                                r_bm    <= '0;
                                r_bd    <= COLS_A;
                                r_k     <= '0;
                                r_cnt   <= '0;
                                r_acc   <= '0;
                                r_state <= S_NB;
                            end
                            default: begin
                                r_state <= S_FRD;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (rdata.alive && !mod_cell.alive) begin
                        r_live <= r_live - LW'(1);
                    end else if (!rdata.alive && mod_cell.alive) begin
                        r_live <= r_live + LW'(1);
                    end
                    r_state <= S_FRD;
                end
                S_NB: begin
                    case (r_k)
                        4'd0: begin
                        end
                        4'd5: begin
                            // previous read was the center cell
                            r_here <= rdata;
                        end
                        default: begin
                            r_cnt <= n_cnt;
                        end
                    endcase
                    if (r_k == 4'd9) begin
                        r_k   <= '0;
                        r_cnt <= '0;
                        r_acc <= r_acc + LW'(nxt_cell.alive);
                        if (r_x == LAST_COL) begin
                            r_x  <= '0;
                            r_y  <= r_y + RW'(1);
                            r_bu <= r_bm;
                            r_bm <= r_bd;
                            r_bd <= (r_bd == LAST_BASE) ? '0 : r_bd + COLS_A;
                            if (r_y == LAST_ROW) begin
                                r_bank  <= ~r_bank;
                                r_gen   <= r_gen + 32'd1;
                                r_live  <= r_acc + LW'(nxt_cell.alive);
                                r_state <= S_FRD;
                            end
                        end else begin
                            r_x <= r_x + CW'(1);
                        end
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_FRD: begin
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    if (slot_free) begin
                        r_out_valid         <= 1'b1;
                        r_res.alive         <= r_inside & rdata.alive;
                        r_res.cell_years    <= r_inside ? rdata.age : 8'd0;
                        r_res.color         <= (r_inside && rdata.alive) ?
                                               band_color(rdata.age) : 24'd0;
                        r_res.live_count    <= (32'(r_live) > 32'(LIVE_MAX)) ?
                                               13'(LIVE_MAX) : 13'(r_live);
                        r_res.generation    <= r_gen;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    // neighborhood sequencer never runs past its last slot
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_NB |-> r_k <= 4'd9)
        else $error("neighbor index out of range");

    // a held result is not overwritten by the next command
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_res))
        else $error("pending result lost");

    // live count never exceeds the grid size
    a_live_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= 32'(CELLS))
        else $error("live count above grid size");

    // next-bank writes only come from the step sweep
    a_nxt_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we_nxt |-> r_state == S_NB && !we_cur)
        else $error("unexpected next bank write");
`endif

endmodule
